/* src/drive_mixer_with_collision_stop_defines.svh */
// ----------------------------------------------------------------------------
// Drive mixer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DRIVE_MIXER_WITH_COLLISION_STOP_DEFINES_SVH
`define DRIVE_MIXER_WITH_COLLISION_STOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define DMCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define DMCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/dmcs_pkg.sv */
// ----------------------------------------------------------------------------
// Drive mixer package
// Widths, register indexes, reciprocal constants and stage payload types.
// ----------------------------------------------------------------------------
package dmcs_pkg;

  // Port widths
  localparam int IN_W   = 56;
  localparam int OUT_W  = 40;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;

  // Number of register stages from input to output register
  localparam int NSTG = 7;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_TOP_SPEED  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MARGIN     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MIN_VALID  = 2'd2;

  // Register reset values
  localparam logic [7:0]  TOP_SPEED_RST = 8'd255;
  localparam logic [11:0] MARGIN_RST    = 12'd100;
  localparam logic [11:0] MIN_VALID_RST = 12'd30;

  // Fixed numbers of the mixing law
  localparam logic [15:0] SUBST_DIST = 16'd500;
  localparam logic [7:0]  TURN_DEAD  = 8'd5;
  localparam logic [7:0]  TURN_FULL  = 8'd45;

  // Reciprocals: floor(n/3) = (n*683)>>11 for n < 2048
  localparam logic [9:0]  RECIP3  = 10'd683;
  // floor(n/5) = (n*13108)>>16 for n < 16384 (divide by 20 = >>2 then /5)
  localparam logic [13:0] RECIP5  = 14'd13108;
  // floor(n/45) = (n*93207)>>22 for n < 381300
  localparam logic [16:0] RECIP45 = 17'd93207;

  // Per-item control carried down the pipe
  typedef struct packed {
    logic [7:0] xmag;
    logic       xneg;
    logic [5:0] fac;
    logic       turn_r;
    logic       turn_l;
    logic       fb;
    logic       bb;
    logic       link;
  } ctl_t;

  typedef struct packed {
    ctl_t       ctl;
    logic [9:0] bprod;
  } s1_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [11:0] q;
    logic [11:0] qs;
  } s6_t;

  typedef struct packed {
    logic [7:0] lf;
    logic [7:0] lr;
    logic [7:0] rf;
    logic [7:0] rr;
    logic       fb;
    logic       bb;
  } res_t;

endpackage

/* src/dmcs_front.sv */
// ----------------------------------------------------------------------------
// Drive mixer front stage
// Decodes tilt, turn side and factor, obstacle flags and the level product.
// ----------------------------------------------------------------------------
module dmcs_front
  import dmcs_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  tilt_x,
  input  logic [7:0]  tilt_y,
  input  logic [1:0]  speed_step,
  input  logic [15:0] dist_back,
  input  logic [15:0] dist_front,
  input  logic        link_up,
  input  logic [7:0]  top_speed,
  input  logic [11:0] safety_margin,
  input  logic [11:0] min_valid_dist,
  output s1_t         s1_r
);

  logic        yneg;
  logic [7:0]  ymag;
  logic [7:0]  yclip;
  logic [7:0]  fac_full;
  logic [10:0] bp_full;
  logic [15:0] db_sub;
  logic [15:0] df_sub;
  logic [15:0] thr;
  s1_t         s1_nxt;

  // Magnitudes, turn side, scale factor, distance checks
  always_comb begin
    yneg     = tilt_y[7];
    ymag     = yneg ? 8'(-tilt_y) : tilt_y;
    yclip    = (ymag > TURN_FULL) ? TURN_FULL : ymag;
    fac_full = TURN_FULL - yclip;
    bp_full  = {3'b000, top_speed} * ({9'd0, speed_step} + 11'd1);
    db_sub   = (dist_back  < {4'h0, min_valid_dist}) ? SUBST_DIST : dist_back;
    df_sub   = (dist_front < {4'h0, min_valid_dist}) ? SUBST_DIST : dist_front;
    thr      = {3'b000, safety_margin, 1'b0};

    s1_nxt.ctl.xneg   = tilt_x[7];
    s1_nxt.ctl.xmag   = tilt_x[7] ? 8'(-tilt_x) : tilt_x;
    s1_nxt.ctl.fac    = fac_full[5:0];
    s1_nxt.ctl.turn_r = !yneg && (ymag > TURN_DEAD);
    s1_nxt.ctl.turn_l = yneg && (ymag > TURN_DEAD);
    s1_nxt.ctl.fb     = df_sub < thr;
    s1_nxt.ctl.bb     = db_sub < thr;
    s1_nxt.ctl.link   = link_up;
    s1_nxt.bprod      = bp_full[9:0];
  end

  // Advance stage
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

/* src/dmcs_mul.sv */
// ----------------------------------------------------------------------------
// Drive mixer multiply chain
// Base speed, tilt product, divide by 20, turn product and divide by 45,
// one multiplication per stage.
// ----------------------------------------------------------------------------
module dmcs_mul
  import dmcs_pkg::*;
(
  input  logic       clk,
  input  logic [4:0] en,
  input  s1_t        s1,
  output s6_t        s6_r
);

  logic [19:0] base_full;
  logic [28:0] q_full;
  logic [17:0] p_full;
  logic [33:0] qs_full;

  ctl_t        c2_r, c3_r, c4_r, c5_r;
  logic [8:0]  base_r;
  logic [16:0] m_r;
  logic [11:0] q4_r, q5_r;
  logic [16:0] p_r;

  always_comb begin
    base_full = {10'd0, s1.bprod} * {10'd0, RECIP3};
    q_full    = {14'd0, m_r[16:2]} * {15'd0, RECIP5};
    p_full    = {6'd0, q4_r} * {12'd0, c4_r.fac};
    qs_full   = {17'd0, p_r} * {17'd0, RECIP45};
  end

  // Base speed = level product / 3
  always_ff @(posedge clk) begin
    if (en[0]) begin
      c2_r   <= s1.ctl;
      base_r <= base_full[19:11];
    end
  end

  // Tilt magnitude times base
  always_ff @(posedge clk) begin
    if (en[1]) begin
      c3_r <= c2_r;
      m_r  <= 17'({9'd0, c2_r.xmag} * {8'd0, base_r});
    end
  end

  // Divide by 20
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c4_r <= c3_r;
      q4_r <= q_full[27:16];
    end
  end

  // Turn product
  always_ff @(posedge clk) begin
    if (en[3]) begin
      c5_r <= c4_r;
      q5_r <= q4_r;
      p_r  <= p_full[16:0];
    end
  end

  // Divide by 45
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s6_r.ctl <= c5_r;
      s6_r.q   <= q5_r;
      s6_r.qs  <= qs_full[33:22];
    end
  end

endmodule

/* src/dmcs_out.sv */
// ----------------------------------------------------------------------------
// Drive mixer output stage
// Picks turned wheel, clamps to limit, applies stops, splits into duties.
// ----------------------------------------------------------------------------
module dmcs_out
  import dmcs_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  s6_t        s6,
  input  logic [7:0] top_speed,
  output res_t       res_r
);

  logic [11:0] lmag;
  logic [11:0] rmag;
  logic [7:0]  lcl;
  logic [7:0]  rcl;
  logic        pos;
  logic        kill;
  res_t        res_nxt;

  always_comb begin
    lmag = s6.ctl.turn_l ? s6.qs : s6.q;
    rmag = s6.ctl.turn_r ? s6.qs : s6.q;
    lcl  = (lmag > {4'h0, top_speed}) ? top_speed : lmag[7:0];
    rcl  = (rmag > {4'h0, top_speed}) ? top_speed : rmag[7:0];
    pos  = !s6.ctl.xneg;
    // Drop motion toward a blocked side, or everything on a dead link
    kill = !s6.ctl.link || (pos && s6.ctl.fb) || (!pos && s6.ctl.bb);

    res_nxt.lf = (!kill && pos)  ? lcl : 8'd0;
    res_nxt.lr = (!kill && !pos) ? lcl : 8'd0;
    res_nxt.rf = (!kill && pos)  ? rcl : 8'd0;
    res_nxt.rr = (!kill && !pos) ? rcl : 8'd0;
    res_nxt.fb = s6.ctl.fb;
    res_nxt.bb = s6.ctl.bb;
  end

  // Hold result until transfer
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* src/drive_mixer_with_collision_stop.sv */
// ----------------------------------------------------------------------------
// Drive mixer with collision stop
// Pipeline: seven register stages, the first loading on the input transfer.
// Throughput: one command per cycle while the output is not stalled; each stage
// loads when empty or draining.
// Reset: rst_n low clears stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module drive_mixer_with_collision_stop
  import dmcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // tilt_x[7:0], tilt_y[15:8], speed_step[17:16], dist_back[33:18],
  // dist_front[49:34], link_up[50], zero pad
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // left_fwd_duty[7:0], left_rev_duty[15:8], right_fwd_duty[23:16],
  // right_rev_duty[31:24], front_blocked[32], back_blocked[33], zero pad
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [7:0]      top_speed_r;
  logic [11:0]     margin_r;
  logic [11:0]     min_valid_r;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;
  s1_t             s1;
  s6_t             s6;
  res_t            res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_speed_r <= TOP_SPEED_RST;
      margin_r    <= MARGIN_RST;
      min_valid_r <= MIN_VALID_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TOP_SPEED: top_speed_r <= cfg_wdata[7:0];
        CFG_MARGIN:    margin_r    <= cfg_wdata;
        CFG_MIN_VALID: min_valid_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage enables: load when empty or when the next stage takes the item
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  dmcs_front u_front (
    .clk            (clk),
    .en             (en[0]),
    .tilt_x         (in_tdata[7:0]),
    .tilt_y         (in_tdata[15:8]),
    .speed_step     (in_tdata[17:16]),
    .dist_back      (in_tdata[33:18]),
    .dist_front     (in_tdata[49:34]),
    .link_up        (in_tdata[50]),
    .top_speed      (top_speed_r),
    .safety_margin  (margin_r),
    .min_valid_dist (min_valid_r),
    .s1_r           (s1)
  );

  dmcs_mul u_mul (
    .clk  (clk),
    .en   (en[5:1]),
    .s1   (s1),
    .s6_r (s6)
  );

  dmcs_out u_out (
    .clk       (clk),
    .en        (en[NSTG-1]),
    .s6        (s6),
    .top_speed (top_speed_r),
    .res_r     (res)
  );

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {6'd0, res.bb, res.fb, res.rr, res.rf, res.lr, res.lf};

endmodule

/* src/dmcs_checker.sv */
// ----------------------------------------------------------------------------
// Drive mixer port checker
// Watches valid results for duty consistency and stall behavior.
// ----------------------------------------------------------------------------
`include "drive_mixer_with_collision_stop_defines.svh"

module dmcs_checker
  import dmcs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // Stalled result holds
  `DMCS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // At most one direction per wheel
  `DMCS_ASSERT_NOW(a_one_dir, out_tvalid, (out_tdata[7:0] == 8'd0 || out_tdata[15:8] == 8'd0) && (out_tdata[23:16] == 8'd0 || out_tdata[31:24] == 8'd0), "both directions driven on a wheel")

  // Front block stops forward motion
  `DMCS_ASSERT_NOW(a_front_stop, out_tvalid && out_tdata[32], out_tdata[7:0] == 8'd0 && out_tdata[23:16] == 8'd0, "forward duty while front blocked")

  // Rear block stops reverse motion
  `DMCS_ASSERT_NOW(a_back_stop, out_tvalid && out_tdata[33], out_tdata[15:8] == 8'd0 && out_tdata[31:24] == 8'd0, "reverse duty while back blocked")

endmodule

bind drive_mixer_with_collision_stop dmcs_checker u_dmcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
